// File: hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked property, skipped while reset is high
`define GPR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");
// checked property, also during reset
`define GPR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: property failed");
`else
`define GPR_ASSERT(lbl, clk, rst, prop)
`define GPR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hdl/gpr_pkg.sv
`timescale 1ns / 1ps

package gpr_pkg;

  // packet kinds on the output channel
  typedef enum logic [1:0] {
    KIND_ANNOUNCE  = 2'd0,
    KIND_KEEPALIVE = 2'd1,
    KIND_REPORT    = 2'd2
  } kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_ANNOUNCE_DELAY = 2'd0;
  localparam logic [1:0] REG_IDLE_INTERVAL  = 2'd1;
  localparam logic [1:0] REG_KEEPALIVE_INT  = 2'd2;

  localparam logic [15:0] ANNOUNCE_DELAY_RST = 16'd500;
  localparam logic [15:0] IDLE_INTERVAL_RST  = 16'd8;
  localparam logic [15:0] KEEPALIVE_INT_RST  = 16'd15000;

  // packet lengths
  localparam int unsigned IDX_W = 6;
  localparam logic [IDX_W-1:0] LEN_ANNOUNCE  = 6'd32;
  localparam logic [IDX_W-1:0] LEN_KEEPALIVE = 6'd8;
  localparam logic [IDX_W-1:0] LEN_REPORT    = 6'd36;

  localparam logic [9:0] ROOM_ANNOUNCE  = 10'd32;
  localparam logic [9:0] ROOM_KEEPALIVE = 10'd8;
  localparam logic [9:0] ROOM_REPORT    = 10'd36;

  localparam int unsigned QUEUE_DEPTH = 2;

  // one scheduled packet, everything the serializer needs
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         seq;
    logic [23:0]        stamp;
    logic [7:0]         btn0;
    logic [7:0]         btn1;
    logic [9:0]         ltrig;
    logic [9:0]         rtrig;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
  } entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // sequence counters skip zero
  function automatic logic [7:0] next_seq(input logic [7:0] s);
    logic [7:0] n;
    n = s + 8'd1;
    return (n == 8'd0) ? 8'd1 : n;
  endfunction

  // announce packet template; bytes 7..9 are replaced by the timestamp
  function automatic logic [7:0] announce_byte(input logic [4:0] i);
    logic [7:0] b;
    case (i)
      5'd0:    b = 8'h02;
      5'd1:    b = 8'h20;
      5'd2:    b = 8'h01;
      5'd3:    b = 8'h1c;
      5'd5:    b = 8'h2a;
      5'd7:    b = 8'hff;
      5'd8:    b = 8'hff;
      5'd9:    b = 8'hff;
      5'd12:   b = 8'hdf;
      5'd13:   b = 8'h33;
      5'd14:   b = 8'h14;
      5'd16:   b = 8'h01;
      5'd18:   b = 8'h01;
      5'd20:   b = 8'h17;
      5'd21:   b = 8'h01;
      5'd22:   b = 8'h02;
      5'd24:   b = 8'h01;
      5'd26:   b = 8'h01;
      5'd28:   b = 8'h01;
      5'd30:   b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/gpr_in_if.sv
`timescale 1ns / 1ps

interface gpr_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [31:0]        now_ms;
  logic               mounted;
  logic [9:0]         tx_room;
  logic [15:0]        buttons;
  logic [7:0]         left_trigger_in;
  logic [7:0]         right_trigger_in;
  logic signed [15:0] left_stick_x;
  logic signed [15:0] left_stick_y;
  logic signed [15:0] right_stick_x;
  logic signed [15:0] right_stick_y;

  modport source (
    output valid, mode, now_ms, mounted, tx_room, buttons, left_trigger_in,
           right_trigger_in, left_stick_x, left_stick_y, right_stick_x, right_stick_y,
    input  ready
  );
  modport sink (
    input  valid, mode, now_ms, mounted, tx_room, buttons, left_trigger_in,
           right_trigger_in, left_stick_x, left_stick_y, right_stick_x, right_stick_y,
    output ready
  );
endinterface

// File: hdl/gpr_out_if.sv
`timescale 1ns / 1ps

interface gpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic [1:0] packet_kind;
  logic       last_byte;

  modport source (output valid, packet_byte, packet_kind, last_byte, input ready);
  modport sink (input valid, packet_byte, packet_kind, last_byte, output ready);
endinterface

// File: hdl/gpr_cfg_if.sv
`timescale 1ns / 1ps

interface gpr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/gpr_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gpr_front
  import gpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  gpr_in_if.sink    poll,
  gpr_cfg_if.sink   cfg,
  input  q_status_t qs,
  output logic      push,
  output entry_t    push_data
);

  // configuration registers
  logic [15:0] announce_delay;
  logic [15:0] idle_interval;
  logic [15:0] keepalive_interval;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      announce_delay     <= ANNOUNCE_DELAY_RST;
      idle_interval      <= IDLE_INTERVAL_RST;
      keepalive_interval <= KEEPALIVE_INT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ANNOUNCE_DELAY: announce_delay     <= cfg.data;
        REG_IDLE_INTERVAL:  idle_interval      <= cfg.data;
        REG_KEEPALIVE_INT:  keepalive_interval <= cfg.data;
        default: ;
      endcase
    end
  end

  // stage 1: register the request with remapped buttons and scaled triggers
  logic               s1_valid;
  logic               s1_mode;
  logic               s1_mounted;
  logic [31:0]        s1_now;
  logic [9:0]         s1_room;
  logic [7:0]         s1_btn0;
  logic [7:0]         s1_btn1;
  logic [9:0]         s1_lt;
  logic [9:0]         s1_rt;
  logic signed [15:0] s1_lx;
  logic signed [15:0] s1_ly;
  logic signed [15:0] s1_rx;
  logic signed [15:0] s1_ry;
  logic               s2_go;

  logic [7:0] btn0_c;
  logic [7:0] btn1_c;
  logic [9:0] lt_c;
  logic [9:0] rt_c;

  // 8 to 10 bit scale: 4v plus rounded 3v/255, quotient found by compares
  function automatic logic [9:0] scale_trig(input logic [7:0] v);
    logic [9:0] t;
    logic [1:0] q;
    t = ({2'b00, v} << 1) + {2'b00, v} + 10'd127;
    q = 2'(t >= 10'd255) + 2'(t >= 10'd510) + 2'(t >= 10'd765);
    return {v, 2'b00} + {8'd0, q};
  endfunction

  always_comb begin
    btn0_c = {poll.buttons[15], poll.buttons[14], poll.buttons[13], poll.buttons[12],
              poll.buttons[5], poll.buttons[4], 2'b00};
    btn1_c = {poll.buttons[7], poll.buttons[6], poll.buttons[9], poll.buttons[8],
              poll.buttons[3], poll.buttons[2], poll.buttons[1], poll.buttons[0]};
    lt_c   = scale_trig(poll.left_trigger_in);
    rt_c   = scale_trig(poll.right_trigger_in);
  end

  assign poll.ready = !s1_valid || s2_go;
  assign s2_go      = s1_valid && !qs.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.ready && poll.valid) begin
      s1_mode    <= poll.mode;
      s1_mounted <= poll.mounted;
      s1_now     <= poll.now_ms;
      s1_room    <= poll.tx_room;
      s1_btn0    <= btn0_c;
      s1_btn1    <= btn1_c;
      s1_lt      <= lt_c;
      s1_rt      <= rt_c;
      s1_lx      <= poll.left_stick_x;
      s1_ly      <= poll.left_stick_y;
      s1_rx      <= poll.right_stick_x;
      s1_ry      <= poll.right_stick_y;
    end
  end

  // scheduler state
  logic        announced, announced_next;
  logic        have_prev, have_prev_next;
  logic [31:0] mount_time, mount_time_next;
  logic [31:0] last_report_time, last_report_time_next;
  logic [31:0] last_keepalive_time, last_keepalive_time_next;
  logic [7:0]  report_seq, report_seq_next;
  logic [7:0]  keepalive_seq, keepalive_seq_next;
  logic [35:0] prev_bt, prev_bt_next;
  logic [63:0] prev_sticks, prev_sticks_next;

  logic [35:0] cur_bt;
  logic [63:0] cur_sticks;
  logic        ann_hit;
  logic        ka_hit;
  logic        rep_due;

  // stage 2 conditions
  always_comb begin
    cur_bt     = {s1_btn0, s1_btn1, s1_lt, s1_rt};
    cur_sticks = {s1_lx, s1_ly, s1_rx, s1_ry};
    ann_hit    = !announced && ((s1_now - mount_time) >= {16'd0, announce_delay})
                 && (s1_room >= ROOM_ANNOUNCE);
    ka_hit     = ((s1_now - last_keepalive_time) >= {16'd0, keepalive_interval})
                 && (s1_room >= ROOM_KEEPALIVE);
    rep_due    = !have_prev || (cur_bt != prev_bt) || (cur_sticks != prev_sticks)
                 || ((s1_now - last_report_time) >= {16'd0, idle_interval});
  end

  // stage 2 decision and state update
  always_comb begin
    announced_next           = announced;
    have_prev_next           = have_prev;
    mount_time_next          = mount_time;
    last_report_time_next    = last_report_time;
    last_keepalive_time_next = last_keepalive_time;
    report_seq_next          = report_seq;
    keepalive_seq_next       = keepalive_seq;
    prev_bt_next             = prev_bt;
    prev_sticks_next         = prev_sticks;
    push                     = 1'b0;
    push_data.kind           = KIND_REPORT;
    push_data.seq            = next_seq(report_seq);
    push_data.stamp          = s1_now[23:0];
    push_data.btn0           = s1_btn0;
    push_data.btn1           = s1_btn1;
    push_data.ltrig          = s1_lt;
    push_data.rtrig          = s1_rt;
    push_data.lx             = s1_lx;
    push_data.ly             = s1_ly;
    push_data.rx             = s1_rx;
    push_data.ry             = s1_ry;
    if (s2_go) begin
      if (s1_mode) begin
        announced_next           = 1'b0;
        have_prev_next           = 1'b0;
        mount_time_next          = s1_now;
        last_report_time_next    = 32'd0;
        last_keepalive_time_next = 32'd0;
        report_seq_next          = 8'd1;
        keepalive_seq_next       = 8'd1;
      end else if (s1_mounted) begin
        if (ann_hit) begin
          announced_next = 1'b1;
          push           = 1'b1;
          push_data.kind = KIND_ANNOUNCE;
          push_data.seq  = 8'd1;
        end else if (ka_hit) begin
          push                     = 1'b1;
          push_data.kind           = KIND_KEEPALIVE;
          push_data.seq            = keepalive_seq;
          keepalive_seq_next       = next_seq(keepalive_seq);
          last_keepalive_time_next = s1_now;
        end else if (rep_due) begin
          report_seq_next = next_seq(report_seq);
          if (s1_room >= ROOM_REPORT) begin
            push                  = 1'b1;
            prev_bt_next          = cur_bt;
            prev_sticks_next      = cur_sticks;
            have_prev_next        = 1'b1;
            last_report_time_next = s1_now;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      announced           <= 1'b0;
      have_prev           <= 1'b0;
      mount_time          <= 32'd0;
      last_report_time    <= 32'd0;
      last_keepalive_time <= 32'd0;
      report_seq          <= 8'd1;
      keepalive_seq       <= 8'd1;
      prev_bt             <= 36'd0;
      prev_sticks         <= 64'd0;
    end else begin
      announced           <= announced_next;
      have_prev           <= have_prev_next;
      mount_time          <= mount_time_next;
      last_report_time    <= last_report_time_next;
      last_keepalive_time <= last_keepalive_time_next;
      report_seq          <= report_seq_next;
      keepalive_seq       <= keepalive_seq_next;
      prev_bt             <= prev_bt_next;
      prev_sticks         <= prev_sticks_next;
    end
  end

  // sequence numbers never reach zero
  `GPR_ASSERT(a_seq_nonzero, clk, rst, (report_seq != 8'd0) && (keepalive_seq != 8'd0))
  // a packet is only scheduled for a mounted poll
  `GPR_ASSERT(a_push_poll, clk, rst, push |-> (s1_valid && !s1_mode && s1_mounted))

endmodule

// File: hdl/gpr_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gpr_queue
  import gpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  entry_t    push_data,
  input  logic      pop,
  output entry_t    head,
  output q_status_t qs
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qs.full  = (count == FULL_CNT);
  assign qs.empty = (count == '0);
  assign head     = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `GPR_ASSERT(a_no_overflow, clk, rst, qs.full |-> !push)
  `GPR_ASSERT(a_no_underflow, clk, rst, qs.empty |-> !pop)

endmodule

// File: hdl/gpr_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gpr_back
  import gpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  entry_t    head,
  input  q_status_t qs,
  output logic      pop,
  gpr_out_if.source pkt
);

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] len;
  logic             at_last;
  logic             load;
  logic [7:0]       byte_c;

  logic             ovalid;
  logic [7:0]       obyte;
  kind_t            okind;
  logic             olast;

  // packet length and end of packet
  always_comb begin
    case (head.kind)
      KIND_ANNOUNCE:  len = LEN_ANNOUNCE;
      KIND_KEEPALIVE: len = LEN_KEEPALIVE;
      default:        len = LEN_REPORT;
    endcase
    at_last = (idx == len - 1'b1);
    load    = !qs.empty && (!ovalid || pkt.ready);
    pop     = load && at_last;
  end

  // byte selection
  always_comb begin
    byte_c = 8'h00;
    case (head.kind)
      KIND_ANNOUNCE: begin
        case (idx)
          6'd7:    byte_c = head.stamp[7:0];
          6'd8:    byte_c = head.stamp[15:8];
          6'd9:    byte_c = head.stamp[23:16];
          default: byte_c = announce_byte(idx[4:0]);
        endcase
      end
      KIND_KEEPALIVE: begin
        case (idx)
          6'd0:    byte_c = 8'h03;
          6'd1:    byte_c = 8'h20;
          6'd2:    byte_c = head.seq;
          6'd3:    byte_c = 8'h04;
          6'd4:    byte_c = 8'h80;
          default: byte_c = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          6'd0:    byte_c = 8'h20;
          6'd2:    byte_c = head.seq;
          6'd3:    byte_c = 8'h20;
          6'd4:    byte_c = head.btn0;
          6'd5:    byte_c = head.btn1;
          6'd6:    byte_c = head.ltrig[7:0];
          6'd7:    byte_c = {6'd0, head.ltrig[9:8]};
          6'd8:    byte_c = head.rtrig[7:0];
          6'd9:    byte_c = {6'd0, head.rtrig[9:8]};
          6'd10:   byte_c = head.lx[7:0];
          6'd11:   byte_c = head.lx[15:8];
          6'd12:   byte_c = head.ly[7:0];
          6'd13:   byte_c = head.ly[15:8];
          6'd14:   byte_c = head.rx[7:0];
          6'd15:   byte_c = head.rx[15:8];
          6'd16:   byte_c = head.ry[7:0];
          6'd17:   byte_c = head.ry[15:8];
          default: byte_c = 8'h00;
        endcase
      end
    endcase
  end

  // byte counter within the packet at the queue head
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= at_last ? '0 : idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load) begin
      ovalid <= 1'b1;
    end else if (pkt.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte <= byte_c;
      okind <= head.kind;
      olast <= at_last;
    end
  end

  assign pkt.valid       = ovalid;
  assign pkt.packet_byte = obyte;
  assign pkt.packet_kind = okind;
  assign pkt.last_byte   = olast;

  // byte counter stays inside the packet
  `GPR_ASSERT(a_idx_range, clk, rst, !qs.empty |-> (idx < len))
  // counter is back at zero whenever the queue runs dry
  `GPR_ASSERT(a_idx_idle, clk, rst, qs.empty |-> (idx == '0))

endmodule

// File: hdl/gamepad_report_scheduler_top.sv
`timescale 1ns / 1ps
// Packet scheduler for a game controller on a vendor USB interface.
// poll: one request per poll tick or bus reset, valid/ready. A bus reset
//   restarts the timers and sequence numbers; a mounted poll yields at most
//   one packet: announce (32 bytes), keepalive (8 bytes) or input report
//   (36 bytes), each only if tx_room holds the whole packet.
// pkt: one packet byte per request, in order, with its kind and an
//   end-of-packet flag.
// cfg: register writes (0 announce delay, 1 idle interval, 2 keepalive
//   period, all in ms); always ready, other indexes are ignored.
// Timing: a poll request is taken every cycle while the two-entry packet
//   queue between scheduler and serializer has room. A poll is registered in
//   the scheduler stage, pushed into the queue and then loaded into the output
//   register as the first byte of its packet. While ready stays high the
//   serializer emits one byte per cycle, which bounds the packet throughput.
// When the receiver holds ready low the current byte is held, the queue fills
//   and poll.ready drops once both entries are taken and a request waits in
//   the scheduler stage.
// Reset (rst, synchronous) loads the register defaults and clears the queue
//   and the scheduler state.

module gamepad_report_scheduler_top
  import gpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  gpr_in_if.sink    poll,
  gpr_cfg_if.sink   cfg,
  gpr_out_if.source pkt
);

  logic      push;
  logic      pop;
  entry_t    push_data;
  entry_t    head;
  q_status_t qs;

  gpr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .poll      (poll),
    .cfg       (cfg),
    .qs        (qs),
    .push      (push),
    .push_data (push_data)
  );

  gpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qs        (qs)
  );

  gpr_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .qs   (qs),
    .pop  (pop),
    .pkt  (pkt)
  );

endmodule
